// ----- sv/autorange_conductivity_meter_core_defines.svh -----
// Assertion macros for the autorange conductivity meter core checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef AUTORANGE_CONDUCTIVITY_METER_CORE_DEFINES_SVH
`define AUTORANGE_CONDUCTIVITY_METER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ACM_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("acm checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define ACM_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("acm checker: next-cycle property failed");

`endif

// ----- sv/acm_pkg.sv -----
// Shared types, constants and sense-range tables of the conductivity meter core.
// No dependencies.
package acm_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int TEMP_W     = 12;
    localparam int RANGE_W    = 2;
    localparam int RES_W      = 39;
    localparam int COND_W     = 40;
    localparam int REG_W      = 16;
    localparam int REG_IDX_W  = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 128;
    localparam int OUT_USER_W = 2;

    // shared divider: left-aligned dividend, divisor, iteration count
    localparam int DVD_W = 52;
    localparam int DSR_W = 39;
    localparam int CNT_W = 6;

    localparam logic [RANGE_W-1:0] RANGE_100K = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_10K  = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_3K   = 2'd2;
    localparam logic [RANGE_W-1:0] RANGE_1K   = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_UPPER_LIMIT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT_10K = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT_3K  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT_1K  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SINE_OFFSET   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CELL_CONSTANT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_COEF     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_WIRE_RES      = 3'd7;

    localparam logic [11:0] RST_UPPER_LIMIT   = 12'd2000;
    localparam logic [11:0] RST_LOW_LIMIT_10K = 12'd390;
    localparam logic [11:0] RST_LOW_LIMIT_3K  = 12'd715;
    localparam logic [11:0] RST_LOW_LIMIT_1K  = 12'd834;
    localparam logic [11:0] RST_SINE_OFFSET   = 12'd266;
    localparam logic [15:0] RST_CELL_CONSTANT = 16'd1077;
    localparam logic [15:0] RST_TEMP_COEF     = 16'd1311;
    localparam logic [15:0] RST_WIRE_RES      = 16'd0;

    localparam logic [COND_W-1:0] COND_MAX = {COND_W{1'b1}};

    typedef struct packed {
        logic [11:0] upper_limit;
        logic [11:0] low_limit_10k;
        logic [11:0] low_limit_3k;
        logic [11:0] low_limit_1k;
        logic [11:0] sine_offset;
        logic [15:0] cell_constant;
        logic [15:0] temp_coef;
        logic [15:0] wire_res_mohm;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_in_use;
        logic               measured;
        logic               below_offset;
        logic [RES_W-1:0]   resistance_mohm;
        logic [COND_W-1:0]  cond_raw;
        logic [COND_W-1:0]  cond_comp;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // sense resistor plus switch on-resistance, ohm
    function automatic logic [16:0] rch_ohm(input logic [RANGE_W-1:0] r);
        logic [16:0] v;
        case (r)
            RANGE_100K: v = 17'd100001;
            RANGE_10K:  v = 17'd10001;
            RANGE_3K:   v = 17'd3001;
            default:    v = 17'd1001;
        endcase
        return v;
    endfunction

    // same resistance times 1000
    function automatic logic [26:0] rch_kilo(input logic [RANGE_W-1:0] r);
        logic [26:0] v;
        case (r)
            RANGE_100K: v = 27'd100001000;
            RANGE_10K:  v = 27'd10001000;
            RANGE_3K:   v = 27'd3001000;
            default:    v = 27'd1001000;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/autorange_conductivity_meter_core.sv -----
// Top level of the autorange conductivity meter: configuration registers and output word.
// Depends on acm_pkg and acm_seq.
//
// channel    | direction | handshake                      | payload
// s_axis     | in        | s_axis_tvalid / s_axis_tready  | sample, temperature
// m_axis     | out       | m_axis_tvalid / m_axis_tready  | range, resistance, conductivities
// cfg        | in        | cfg_wr_en                      | cfg_index, cfg_data
//
// Out-of-window and below-offset words go from accept straight to the finish state.
// A measured word: the shared divider resolves one quotient bit per cycle
// over 39 + 48 bits, then a reciprocal multiply divides by ten; zero offset
// skips the 48-bit division, comp saturation skips the lower half of the divide by ten.
// Ready is low while a word is in flight; the finished word sits in the output register.
// Asynchronous active-low reset restores the register defaults and the 100k range.
module autorange_conductivity_meter_core
    import acm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample[11:0], temperature[23:12]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // range_in_use[1:0], resistance_mohm[40:2], cond_raw[80:41], cond_comp[120:81], zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // measured[0], below_offset[1]
    input  logic                  cfg_wr_en,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]      cfg_data
);

    cfg_t    cfg_reg;
    result_t out_reg;
    result_t res;
    logic    out_valid_reg;
    logic    res_free;
    logic    res_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_limit   <= RST_UPPER_LIMIT;
            cfg_reg.low_limit_10k <= RST_LOW_LIMIT_10K;
            cfg_reg.low_limit_3k  <= RST_LOW_LIMIT_3K;
            cfg_reg.low_limit_1k  <= RST_LOW_LIMIT_1K;
            cfg_reg.sine_offset   <= RST_SINE_OFFSET;
            cfg_reg.cell_constant <= RST_CELL_CONSTANT;
            cfg_reg.temp_coef     <= RST_TEMP_COEF;
            cfg_reg.wire_res_mohm <= RST_WIRE_RES;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_UPPER_LIMIT:   cfg_reg.upper_limit   <= cfg_data[11:0];
                REG_LOW_LIMIT_10K: cfg_reg.low_limit_10k <= cfg_data[11:0];
                REG_LOW_LIMIT_3K:  cfg_reg.low_limit_3k  <= cfg_data[11:0];
                REG_LOW_LIMIT_1K:  cfg_reg.low_limit_1k  <= cfg_data[11:0];
                REG_SINE_OFFSET:   cfg_reg.sine_offset   <= cfg_data[11:0];
                REG_CELL_CONSTANT: cfg_reg.cell_constant <= cfg_data;
                REG_TEMP_COEF:     cfg_reg.temp_coef     <= cfg_data;
                default:           cfg_reg.wire_res_mohm <= cfg_data;
            endcase
        end
    end

    acm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .sample      (s_axis_tdata[11:0]),
        .temperature (s_axis_tdata[23:12]),
        .res_free    (res_free),
        .res_load    (res_load),
        .res         (res)
    );

    // free when empty or being drained this cycle
    assign res_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_reg.cond_comp, out_reg.cond_raw,
                            out_reg.resistance_mohm, out_reg.range_in_use};
    assign m_axis_tuser  = {out_reg.below_offset, out_reg.measured};

endmodule

// ----- sv/acm_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on acm_pkg.
module acm_div
    import acm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [DVD_W-1:0] quotient
);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DSR_W:0] trial;
    logic [DSR_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.count;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // shift the quotient bit in where the dividend bit leaves
            dvd_next = {dvd_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (req.start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

// ----- sv/acm_seq.sv -----
// Sequencer and datapath: range window, products, two divisions on acm_div
// and a reciprocal divide by ten. Depends on acm_pkg and acm_div.
module acm_seq
    import acm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SAMPLE_W-1:0]      sample,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic                     res_free,
    output logic                     res_load,
    output result_t                  res
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MUL1 = 11'b000_0000_0010,
        S_MUL2 = 11'b000_0000_0100,
        S_LRES = 11'b000_0000_1000,
        S_WRES = 11'b000_0001_0000,
        S_LRAW = 11'b000_0010_0000,
        S_WRAW = 11'b000_0100_0000,
        S_MULC = 11'b000_1000_0000,
        S_LCMP = 11'b001_0000_0000,
        S_WCMP = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } state_t;

    localparam logic [CNT_W-1:0] CNT_RES = 6'd39;
    localparam logic [CNT_W-1:0] CNT_RAW = 6'd48;
    localparam logic [DVD_W-1:0] CMP_SAT_LIM = 52'd10 << COND_W;
    // floor(x / 10) == (x * RCP_TEN) >> 35 for any 32-bit x
    localparam logic [31:0]      RCP_TEN = 32'hCCCCCCCD;

    state_t state_reg, state_next;
    logic [RANGE_W-1:0] range_reg, range_next;

    logic signed [TEMP_W-1:0] t_reg;
    logic [SAMPLE_W-1:0] d_reg;
    logic [RANGE_W-1:0]  rng_reg;
    logic                meas_reg;
    logic                below_reg;
    logic                offz_reg;
    logic [RES_W-1:0]    res_reg;
    logic [COND_W-1:0]   raw_reg;
    logic [COND_W-1:0]   comp_reg;
    logic [38:0]         n1_reg;
    logic [27:0]         dk_reg;
    logic [47:0]         n2_reg;
    logic [38:0]         d2_reg;
    logic [27:0]         uf_reg;
    logic [67:0]         p_reg;
    logic [17:0]         qh_reg;
    logic [3:0]          rh_reg;

    logic accept;
    logic in_win;

    div_req_t         dreq;
    div_stat_t        dstat;
    logic [DVD_W-1:0] ddvd;
    logic [DSR_W-1:0] ddsr;
    logic [DVD_W-1:0] dquo;

    logic signed [12:0] tdiff;
    logic signed [29:0] tprod;
    logic signed [29:0] fac;
    logic [28:0]        offrc;
    logic [27:0]        dk;
    logic [55:0]        pmul;
    logic [38:0]        base;
    logic [DVD_W-1:0]   ph;
    logic               csat;
    logic [31:0]        rcp_in;
    logic [63:0]        rcp_prod;
    logic [28:0]        rcp_q;
    logic [21:0]        rcp_back;
    logic [3:0]         rh;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        case (range_reg)
            RANGE_100K: in_win = (sample <= cfg.upper_limit);
            RANGE_10K:  in_win = (sample >= cfg.low_limit_10k) && (sample <= cfg.upper_limit);
            RANGE_3K:   in_win = (sample >= cfg.low_limit_3k) && (sample <= cfg.upper_limit);
            default:    in_win = (sample >= cfg.low_limit_1k);
        endcase
    end

    // compensation factor 655360 + a*(250 - T), kept only when positive
    assign tdiff = 13'sd250 - $signed({t_reg[TEMP_W-1], t_reg});
    assign tprod = $signed({1'b0, cfg.temp_coef}) * tdiff;
    assign fac   = 30'sd655360 + tprod;

    assign offrc = cfg.sine_offset * rch_ohm(rng_reg);
    assign dk    = d_reg * cfg.cell_constant;
    assign pmul  = raw_reg[27:0] * uf_reg;
    assign base  = dquo[38:0];
    assign ph    = p_reg[67:16];
    assign csat  = (ph >= CMP_SAT_LIM);

    // divide ph by ten in two halves: upper 22 bits first, then remainder and lower 22 bits
    assign rcp_in   = (state_reg == S_LCMP) ? {10'b0, ph[43:22]} : {6'b0, rh_reg, ph[21:0]};
    assign rcp_prod = rcp_in * RCP_TEN;
    assign rcp_q    = rcp_prod[63:35];
    assign rcp_back = {4'b0, rcp_q[17:0]} * 22'd10;
    assign rh       = ph[25:22] - rcp_back[3:0];

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.count = CNT_RES;
        ddvd       = {n1_reg, 13'b0};
        ddsr       = {27'b0, d_reg};
        case (state_reg)
            S_LRES:
            begin
                dreq.start = 1'b1;
            end
            S_LRAW:
            begin
                dreq.start = 1'b1;
                dreq.count = CNT_RAW;
                ddvd       = {n2_reg, 4'b0};
                ddsr       = d2_reg;
            end
            default:
            begin
                dreq.start = 1'b0;
            end
        endcase
    end

    acm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .dividend (ddvd),
        .divisor  (ddsr),
        .stat     (dstat),
        .quotient (dquo)
    );

    always_comb
    begin
        state_next = state_reg;
        range_next = range_reg;
        res_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!in_win)
                    begin
                        range_next = range_reg + RANGE_W'(1);
                        state_next = S_FIN;
                    end
                    else if (sample <= cfg.sine_offset)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_LRES;
            S_LRES: state_next = S_WRES;
            S_WRES:
            begin
                if (dstat.done)
                begin
                    state_next = offz_reg ? S_MULC : S_LRAW;
                end
            end
            S_LRAW: state_next = S_WRAW;
            S_WRAW:
            begin
                if (dstat.done)
                begin
                    state_next = S_MULC;
                end
            end
            S_MULC: state_next = S_LCMP;
            S_LCMP: state_next = csat ? S_FIN : S_WCMP;
            S_WCMP: state_next = S_FIN;
            S_FIN:
            begin
                res_load = res_free;
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            range_reg <= RANGE_100K;
        end
        else
        begin
            state_reg <= state_next;
            range_reg <= range_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    t_reg     <= temperature;
                    d_reg     <= sample - cfg.sine_offset;
                    rng_reg   <= range_reg;
                    res_reg   <= '0;
                    raw_reg   <= '0;
                    comp_reg  <= '0;
                    meas_reg  <= in_win && (sample > cfg.sine_offset);
                    below_reg <= in_win && (sample <= cfg.sine_offset);
                end
            end
            S_MUL1:
            begin
                n1_reg   <= cfg.sine_offset * rch_kilo(rng_reg);
                dk_reg   <= dk;
                offz_reg <= (cfg.sine_offset == 12'd0);
            end
            S_MUL2:
            begin
                n2_reg <= dk_reg * 20'd1000000;
                d2_reg <= {offrc, 10'b0};
                uf_reg <= (fac > 30'sd0) ? fac[27:0] : 28'd0;
            end
            S_WRES:
            begin
                if (dstat.done)
                begin
                    res_reg <= (base > {23'b0, cfg.wire_res_mohm})
                               ? base - {23'b0, cfg.wire_res_mohm} : '0;
                    if (offz_reg)
                    begin
                        raw_reg <= COND_MAX;
                    end
                end
            end
            S_WRAW:
            begin
                if (dstat.done)
                begin
                    raw_reg <= dquo[COND_W-1:0];
                end
            end
            S_MULC:
            begin
                // saturated raw is all ones: raw*uf becomes (uf << 40) - uf
                p_reg <= offz_reg ? ({uf_reg, 40'b0} - {40'b0, uf_reg}) : {12'b0, pmul};
            end
            S_LCMP:
            begin
                if (csat)
                begin
                    comp_reg <= COND_MAX;
                end
                else
                begin
                    qh_reg <= rcp_q[17:0];
                    rh_reg <= rh;
                end
            end
            S_WCMP:
            begin
                comp_reg <= {qh_reg, rcp_q[21:0]};
            end
            default:
            begin
            end
        endcase
    end

    assign res.range_in_use    = rng_reg;
    assign res.measured        = meas_reg;
    assign res.below_offset    = below_reg;
    assign res.resistance_mohm = res_reg;
    assign res.cond_raw        = raw_reg;
    assign res.cond_comp       = comp_reg;

endmodule

// ----- sv/acm_checker.sv -----
// Port-level checker for the conductivity meter core, bound to the top level.
// Depends on acm_pkg and autorange_conductivity_meter_core_defines.svh.
`include "autorange_conductivity_meter_core_defines.svh"

module acm_checker
    import acm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // stalled word holds
    `ACM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // measured and below-offset never together
    `ACM_ASSERT_NOW(a_flags_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))

    // no measurement means all value fields are zero
    `ACM_ASSERT_NOW(a_idle_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[120:2] == 119'd0)

    // zero raw conductivity cannot compensate to anything else
    `ACM_ASSERT_NOW(a_comp_zero, m_axis_tvalid && (m_axis_tdata[80:41] == 40'd0), m_axis_tdata[120:81] == 40'd0)

    // the sequencer is busy right after taking a word
    `ACM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind autorange_conductivity_meter_core acm_checker u_acm_checker (.*);
